FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by the core design file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: design/wmcs_pkg.sv
// ----------------------------------------------------------------------------
// wmcs_pkg
// types, register map, constants and sine table builder for the column synth
// ----------------------------------------------------------------------------
package wmcs_pkg;

    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int MASK_BITS = 8;
    localparam int ACC_W     = 20;  // up to eight rows of +-32768
    localparam int COS_W     = 17;  // -32768 .. 32768
    localparam int AMP_W     = 15;
    localparam int LEN_W     = 16;
    localparam int P1_W      = ACC_W + COS_W;
    localparam int P2_W      = P1_W + AMP_W + 1;
    localparam int PROD_SHIFT = 30;

    // register indexes, taken from paddr[4:2]
    localparam logic [2:0] REG_TOP_STEP    = 3'd0;
    localparam logic [2:0] REG_ROW_SPACING = 3'd1;
    localparam logic [2:0] REG_COLUMN_LEN  = 3'd2;
    localparam logic [2:0] REG_WIN_STEP    = 3'd3;
    localparam logic [2:0] REG_AMPLITUDE   = 3'd4;

    localparam logic [31:0]      RST_TOP_STEP    = 32'd2058005163;
    localparam logic [31:0]      RST_ROW_SPACING = 32'd12782641;
    localparam logic [LEN_W-1:0] RST_COLUMN_LEN  = 16'd480;
    localparam logic [31:0]      RST_WIN_STEP    = 32'd4483265;
    localparam logic [AMP_W-1:0] RST_AMPLITUDE   = 15'd4095;

    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;

    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

    // reciprocals of the series divisors (2n)(2n+1), rounded up
    localparam int RECIP_SHIFT = 48;
    localparam logic [6:1][63:0] TAYLOR_RECIP = {
        ((64'd1 << RECIP_SHIFT) / 64'd156) + 64'd1,
        ((64'd1 << RECIP_SHIFT) / 64'd110) + 64'd1,
        ((64'd1 << RECIP_SHIFT) / 64'd72) + 64'd1,
        ((64'd1 << RECIP_SHIFT) / 64'd42) + 64'd1,
        ((64'd1 << RECIP_SHIFT) / 64'd20) + 64'd1,
        ((64'd1 << RECIP_SHIFT) / 64'd6) + 64'd1
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_ACC,
        S_MUL1,
        S_MUL2,
        S_OUT
    } t_state;

    typedef struct packed {
        logic mul1;
        logic mul2;
    } t_scale_ctrl;

    // entry k of the quarter-wave sine table in Q15, Taylor series in Q30
    function automatic logic [15:0] sine_entry(input int unsigned k,
                                               input int unsigned tb);
        longint unsigned th;
        longint unsigned t2;
        longint unsigned term;
        longint          sum;
        logic [127:0]    wide;
        begin
            th   = (64'(k) * HALF_PI_Q30) >> tb;
            t2   = (th * th) >> 30;
            term = th;
            sum  = longint'(th);
            for (int n = 1; n <= 6; n++) begin
                term = (term * t2) >> 30;
                // truncating divide as a reciprocal multiply, exact for terms below 2^33
                wide = 128'(term) * 128'(TAYLOR_RECIP[n]);
                term = 64'(wide >> RECIP_SHIFT);
                if ((n & 1) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            sum = (sum + 64'sd16384) >>> 15;
            if (sum > 32768) begin
                sum = 32768;
            end
            return 16'(sum);
        end
    endfunction

endpackage

FILE: design/wmcs_cos_unit.sv
// ----------------------------------------------------------------------------
// wmcs_cos_unit
// cosine of a 32-bit phase from a quarter-wave table, registered result
// ----------------------------------------------------------------------------
module wmcs_cos_unit import wmcs_pkg::*; #(
    parameter int TABLE_BITS = 10
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [31:0]             i_phase,
    output logic signed [COS_W-1:0] o_cos
);

    localparam int N  = 1 << TABLE_BITS;
    localparam int AW = TABLE_BITS + 1;

    logic [15:0]           rom_w [0:N];
    logic [TABLE_BITS-1:0] idx;
    logic [AW-1:0]         addr;
    logic                  flip;
    logic                  neg;
    logic [15:0]           r_mag;
    logic                  r_neg;

    for (genvar k = 0; k <= N; k++) begin : g_rom
        assign rom_w[k] = sine_entry(k, TABLE_BITS);
    end

    // quadrants 0 and 2 read the table mirrored, 1 and 2 are negative
    assign idx  = i_phase[29 -: TABLE_BITS];
    assign flip = ~i_phase[30];
    assign neg  = i_phase[30] ^ i_phase[31];
    assign addr = flip ? (AW'(N) - {1'b0, idx}) : {1'b0, idx};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= rom_w[addr];
            r_neg <= neg;
        end
    end

    assign o_cos = r_neg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});

endmodule

FILE: design/wmcs_scaler.sv
// ----------------------------------------------------------------------------
// wmcs_scaler
// tone sum times window times amplitude, truncate toward zero, saturate
// ----------------------------------------------------------------------------
module wmcs_scaler import wmcs_pkg::*; (
    input  logic                    i_clk,
    input  t_scale_ctrl             i_ctrl,
    input  logic signed [ACC_W-1:0] i_acc,
    input  logic signed [COS_W-1:0] i_win,
    input  logic [AMP_W-1:0]        i_amp,
    output logic signed [15:0]      o_sample
);

    logic signed [P1_W-1:0] r_p1;
    logic signed [P2_W-1:0] r_p2;
    logic [P2_W-1:0]        mag;
    logic [P2_W-PROD_SHIFT-1:0] mag_hi;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul1) begin
            r_p1 <= i_acc * i_win;
        end
        if (i_ctrl.mul2) begin
            r_p2 <= r_p1 * $signed({1'b0, i_amp});
        end
    end

    always_comb begin
        mag    = r_p2[P2_W-1] ? P2_W'(-r_p2) : P2_W'(r_p2);
        mag_hi = mag[P2_W-1:PROD_SHIFT];
        if (r_p2[P2_W-1]) begin
            if (mag_hi > 32768) begin
                o_sample = SAMPLE_MIN;
            end else begin
                o_sample = -$signed(mag_hi[15:0]);
            end
        end else begin
            if (mag_hi > 32767) begin
                o_sample = SAMPLE_MAX;
            end else begin
                o_sample = $signed(mag_hi[15:0]);
            end
        end
    end

endmodule

FILE: design/windowed_multitone_column_synth_core.sv
// ----------------------------------------------------------------------------
// windowed_multitone_column_synth_core
// one audio sample per transfer: sum of row cosines under a half-sine window
// ----------------------------------------------------------------------------
//  channel   direction  handshake                       payload
//  in        input      i_in_valid / o_in_stall         i_column_mask
//  out       output     o_out_valid / i_out_stall       o_audio_sample, o_column_end
//  cfg       input      psel penable pwrite pready      paddr, pwdata, prdata
//
//  each sample is worked out by the single cosine table, which serves every row
//  and then the window in turn, with a lookup state and an accumulate state for each
//  the two multiplies of the scaler run in back-to-back cycles after that
//  reset restores the register defaults and zeroes all phases and the index
//  a new item is taken while the previous sample still waits in the output
//  register; a stalled output holds the sequencer in its final state
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module windowed_multitone_column_synth_core import wmcs_pkg::*; #(
    parameter int ROWS       = 8,
    parameter int TABLE_BITS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_column_mask,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_audio_sample,
    output logic               o_column_end,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    localparam int CW = $clog2(ROWS + 1);
    localparam int RW = $clog2(ROWS);

    t_state r_state;
    t_state n_state;

    logic [31:0]      r_top_step;
    logic [31:0]      r_row_spacing;
    logic [LEN_W-1:0] r_col_len;
    logic [31:0]      r_win_step;
    logic [AMP_W-1:0] r_amp;

    logic [31:0]      r_row_phase [0:ROWS-1];
    logic [31:0]      r_win_phase;
    logic [LEN_W-1:0] r_index;

    logic [7:0]              r_mask;
    logic                    r_last;
    logic [CW-1:0]           r_cnt;
    logic [31:0]             r_inc;
    logic signed [ACC_W-1:0] r_acc;

    logic               r_out_valid;
    logic signed [15:0] r_out_sample;
    logic               r_out_end;

    logic                    in_xfer;
    logic                    cfg_wr;
    logic                    lookup_en;
    logic                    out_load;
    logic                    row_phase_sel;
    logic                    sound;
    logic [31:0]             look_phase;
    logic signed [COS_W-1:0] cos_val;
    logic signed [15:0]      sample;
    t_scale_ctrl             scale_ctrl;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_step    <= RST_TOP_STEP;
            r_row_spacing <= RST_ROW_SPACING;
            r_col_len     <= RST_COLUMN_LEN;
            r_win_step    <= RST_WIN_STEP;
            r_amp         <= RST_AMPLITUDE;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_TOP_STEP:    r_top_step    <= pwdata;
                REG_ROW_SPACING: r_row_spacing <= pwdata;
                REG_COLUMN_LEN:  r_col_len     <= pwdata[LEN_W-1:0];
                REG_WIN_STEP:    r_win_step    <= pwdata;
                REG_AMPLITUDE:   r_amp         <= pwdata[AMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_TOP_STEP:    prdata = r_top_step;
            REG_ROW_SPACING: prdata = r_row_spacing;
            REG_COLUMN_LEN:  prdata = DATA_W'(r_col_len);
            REG_WIN_STEP:    prdata = r_win_step;
            REG_AMPLITUDE:   prdata = DATA_W'(r_amp);
            default:         prdata = '0;
        endcase
    end

    // sequencer
    assign in_xfer       = i_in_valid & ~o_in_stall;
    assign row_phase_sel = (r_cnt < CW'(ROWS));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_xfer) n_state = S_LOOK;
            S_LOOK: n_state = S_ACC;
            S_ACC:  n_state = row_phase_sel ? S_LOOK : S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_OUT;
            S_OUT:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall      = (r_state != S_IDLE);
        lookup_en       = (r_state == S_LOOK);
        scale_ctrl.mul1 = (r_state == S_MUL1);
        scale_ctrl.mul2 = (r_state == S_MUL2);
        out_load        = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // last loop pass looks up the window, sin(w) = cos(w - quarter turn)
    assign look_phase = row_phase_sel ? r_row_phase[r_cnt[RW-1:0]]
                                      : (r_win_phase - QUARTER_TURN);
    assign sound = (32'(r_cnt) < MASK_BITS) && r_mask[3'(r_cnt)];

    wmcs_cos_unit #(
        .TABLE_BITS(TABLE_BITS)
    ) u_cos (
        .i_clk  (i_clk),
        .i_en   (lookup_en),
        .i_phase(look_phase),
        .o_cos  (cos_val)
    );

    wmcs_scaler u_scaler (
        .i_clk   (i_clk),
        .i_ctrl  (scale_ctrl),
        .i_acc   (r_acc),
        .i_win   (cos_val),
        .i_amp   (r_amp),
        .o_sample(sample)
    );

    // item work registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_mask <= i_column_mask;
            r_last <= ((17'(r_index) + 17'd1) >= 17'(r_col_len));
            r_inc  <= r_top_step;
            r_acc  <= '0;
        end
        if (lookup_en && row_phase_sel) begin
            r_inc <= r_inc - r_row_spacing;
        end
        if (r_state == S_ACC && row_phase_sel && sound) begin
            r_acc <= r_acc + ACC_W'(cos_val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_xfer) begin
            r_cnt <= '0;
        end else if (r_state == S_ACC && row_phase_sel) begin
            r_cnt <= r_cnt + CW'(1);
        end
    end

    // phase state, all restarted at the end of a column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int y = 0; y < ROWS; y++) begin
                r_row_phase[y] <= '0;
            end
            r_win_phase <= '0;
            r_index     <= '0;
        end else begin
            if (lookup_en && row_phase_sel) begin
                r_row_phase[r_cnt[RW-1:0]] <= r_last ? '0
                    : (r_row_phase[r_cnt[RW-1:0]] + r_inc);
            end
            if (scale_ctrl.mul1) begin
                r_win_phase <= r_last ? '0 : (r_win_phase + r_win_step);
                r_index     <= r_last ? '0 : (r_index + LEN_W'(1));
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_sample <= sample;
            r_out_end    <= r_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_audio_sample = r_out_sample;
    assign o_column_end   = r_out_end;

    `ASSERT_PROP(a_start_row0, i_clk, i_rst_n, in_xfer |=> (r_state == S_LOOK && r_cnt == '0), "accepted transfer did not start at the first row")
    `ASSERT_NEVER(a_cnt_range, i_clk, i_rst_n, r_cnt > CW'(ROWS), "row counter beyond the window pass")
    `ASSERT_PROP(a_end_restart, i_clk, i_rst_n, ($rose(r_out_valid) && r_out_end) |-> (r_index == '0 && r_win_phase == '0), "column end without restarted state")
    `ASSERT_PROP(a_load_free, i_clk, i_rst_n, out_load |-> (!r_out_valid || !i_out_stall), "output register overwritten while stalled")

endmodule

FILE: bench/windowed_multitone_column_synth_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_multitone_column_synth_core_test
// self-checking bench: per-transfer sample prediction from a local copy of the
// row phases, the fade window and the registers; random gaps and stalls on
// both channels, register settings changed between phases while idle
// ----------------------------------------------------------------------------
module windowed_multitone_column_synth_core_test;
    import wmcs_pkg::*;

    localparam int ROWS     = 8;
    localparam int TAB_BITS = 10;
    localparam int TAB_N    = 1 << TAB_BITS;

    typedef struct {
        logic signed [15:0] audio;
        logic               col_end;
    } t_synth_out;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [7:0]        i_column_mask = 8'h00;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic signed [15:0] o_audio_sample;
    logic              o_column_end;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // register copies
    logic [31:0]      cfg_top_step    = RST_TOP_STEP;
    logic [31:0]      cfg_row_spacing = RST_ROW_SPACING;
    logic [LEN_W-1:0] cfg_col_len     = RST_COLUMN_LEN;
    logic [31:0]      cfg_win_step    = RST_WIN_STEP;
    logic [AMP_W-1:0] cfg_amp         = RST_AMPLITUDE;

    // synth state copies
    logic [15:0] sample_idx = '0;
    logic [31:0] row_phase [ROWS];
    logic [31:0] win_phase = '0;
    int          sine_tab [0:TAB_N];

    logic [7:0]  pending_masks [$];
    t_synth_out  predicted_samples [$];
    t_synth_out  due_sample;
    int          items_queued = 0;
    int          samples_accepted = 0;
    int          mismatches = 0;
    int          in_pause = 0;
    int          out_hold = 0;
    bit          steady_in = 1'b0;
    bit          steady_out = 1'b0;

    windowed_multitone_column_synth_core #(
        .ROWS       (ROWS),
        .TABLE_BITS (TAB_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_column_mask  (i_column_mask),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_audio_sample (o_audio_sample),
        .o_column_end   (o_column_end),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // quarter-wave sine entry in q15 from a q30 taylor series
    function automatic int quarter_sine(input int k);
        longint unsigned ang;
        longint unsigned ang2;
        longint unsigned term;
        longint          acc;
        begin
            ang  = k;
            ang  = (ang * HALF_PI_Q30) >> TAB_BITS;
            ang2 = (ang * ang) >> 30;
            term = ang;
            acc  = longint'(ang);
            for (int n = 1; n <= 6; n++) begin
                term = (term * ang2) >> 30;
                term = term / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            acc = (acc + 16384) >>> 15;
            if (acc > 32768) begin
                acc = 32768;
            end
            return int'(acc);
        end
    endfunction

    function automatic int cos_lookup(input logic [31:0] p);
        int i;
        begin
            i = int'(p[29 -: TAB_BITS]);
            // quadrant picks mirrored index and sign
            case (p[31:30])
                2'd0: return sine_tab[TAB_N - i];
                2'd1: return -sine_tab[i];
                2'd2: return -sine_tab[TAB_N - i];
                default: return sine_tab[i];
            endcase
        end
    endfunction

    // next sample for one column mask, advances the phase state
    function automatic t_synth_out synth_sample(input logic [7:0] mask);
        t_synth_out r;
        longint     acc;
        longint     prod;
        longint     mag;
        begin
            acc = 0;
            for (int y = 0; y < ROWS; y++) begin
                if (mask[y]) begin
                    acc = acc + cos_lookup(row_phase[y]);
                end
            end
            prod = acc * longint'(cos_lookup(win_phase - QUARTER_TURN)) * longint'(cfg_amp);
            mag  = (prod < 0) ? -prod : prod;
            mag  = mag >>> PROD_SHIFT;
            if (prod < 0) begin
                r.audio = (mag > 32768) ? SAMPLE_MIN : 16'(-mag);
            end else begin
                r.audio = (mag > 32767) ? SAMPLE_MAX : 16'(mag);
            end
            r.col_end = (int'(sample_idx) + 1 >= int'(cfg_col_len));
            if (r.col_end) begin
                sample_idx = '0;
                win_phase  = '0;
                for (int y = 0; y < ROWS; y++) begin
                    row_phase[y] = '0;
                end
            end else begin
                sample_idx = sample_idx + 16'd1;
                win_phase  = win_phase + cfg_win_step;
                for (int y = 0; y < ROWS; y++) begin
                    row_phase[y] = row_phase[y] + cfg_top_step - 32'(y) * cfg_row_spacing;
                end
            end
            return r;
        end
    endfunction

    // mostly short pauses, a few long ones
    function automatic int pick_pause();
        int roll;
        begin
            roll = $urandom_range(99);
            if (roll < 55) begin
                return 0;
            end else if (roll < 90) begin
                return $urandom_range(1, 3);
            end
            return $urandom_range(8, 50);
        end
    endfunction

    function automatic logic [31:0] pick_step();
        begin
            case ($urandom_range(9))
                0: return 32'h0000_0000;
                1: return 32'h8000_0000;
                2: return 32'hFFFF_FFFF;
                3, 4, 5: return $urandom;
                default: return $urandom_range(32'h0800_0000);
            endcase
        end
    endfunction

    task automatic reg_read_check(input logic [2:0] idx);
        logic [31:0] want;
        logic [31:0] keep;
        begin
            case (idx)
                REG_TOP_STEP: begin
                    want = cfg_top_step;
                    keep = 32'hFFFF_FFFF;
                end
                REG_ROW_SPACING: begin
                    want = cfg_row_spacing;
                    keep = 32'hFFFF_FFFF;
                end
                REG_COLUMN_LEN: begin
                    want = 32'(cfg_col_len);
                    keep = 32'h0000_FFFF;
                end
                REG_WIN_STEP: begin
                    want = cfg_win_step;
                    keep = 32'hFFFF_FFFF;
                end
                default: begin
                    want = 32'(cfg_amp);
                    keep = 32'h0000_7FFF;
                end
            endcase
            @(posedge i_clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {idx, 2'b00};
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
            if ((prdata & keep) !== (want & keep)) begin
                $display("%0t: register %0d read expected %h got %h", $time, idx,
                         want & keep, prdata & keep);
                mismatches++;
            end
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        begin
            @(posedge i_clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx, 2'b00};
            pwdata  <= val;
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            case (idx)
                REG_TOP_STEP:    cfg_top_step    = val;
                REG_ROW_SPACING: cfg_row_spacing = val;
                REG_COLUMN_LEN:  cfg_col_len     = val[LEN_W-1:0];
                REG_WIN_STEP:    cfg_win_step    = val;
                default:         cfg_amp         = val[AMP_W-1:0];
            endcase
            reg_read_check(idx);
        end
    endtask

    task automatic send_mask(input logic [7:0] m);
        begin
            pending_masks.push_back(m);
            items_queued++;
        end
    endtask

    // hold until every queued transfer has its sample back
    task automatic drain();
        begin
            @(negedge i_clk);
            while (samples_accepted != items_queued || predicted_samples.size() != 0) begin
                @(negedge i_clk);
            end
            repeat (4) @(negedge i_clk);
        end
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predicted_samples.push_back(synth_sample(i_column_mask));
                samples_accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (in_pause > 0) begin
                    in_pause--;
                    i_in_valid    <= 1'b0;
                    i_column_mask <= 8'($urandom);
                end else if (pending_masks.size() > 0) begin
                    i_in_valid    <= 1'b1;
                    i_column_mask <= pending_masks.pop_front();
                    if ($urandom_range(63) == 0) begin
                        steady_in = !steady_in;
                    end
                    in_pause = steady_in ? 0 : pick_pause();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor and stall generator
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (predicted_samples.size() == 0) begin
                    $display("%0t: unexpected sample %0d end %0b", $time,
                             o_audio_sample, o_column_end);
                    mismatches++;
                end else begin
                    due_sample = predicted_samples.pop_front();
                    if (o_audio_sample !== due_sample.audio) begin
                        $display("%0t: audio_sample expected %0d got %0d", $time,
                                 due_sample.audio, o_audio_sample);
                        mismatches++;
                    end
                    if (o_column_end !== due_sample.col_end) begin
                        $display("%0t: column_end expected %0b got %0b", $time,
                                 due_sample.col_end, o_column_end);
                        mismatches++;
                    end
                end
            end
            if ($urandom_range(199) == 0) begin
                steady_out = !steady_out;
            end
            if (out_hold > 0) begin
                out_hold--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if (!steady_out && $urandom_range(99) < 20) begin
                    out_hold = pick_pause();
                end
            end
        end
    end

    initial begin
        #12_000_000;
        $display("[windowed_multitone_column_synth_core] ERROR");
        $finish;
    end

    initial begin
        logic [2:0] reg_list [5];
        logic [7:0] m;
        int         burst;
        reg_list = '{REG_TOP_STEP, REG_ROW_SPACING, REG_COLUMN_LEN, REG_WIN_STEP, REG_AMPLITUDE};
        for (int k = 0; k <= TAB_N; k++) begin
            sine_tab[k] = quarter_sine(k);
        end
        for (int y = 0; y < ROWS; y++) begin
            row_phase[y] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (reg_list[r]) begin
            reg_read_check(reg_list[r]);
        end

        // reset settings, extremes of the mask
        send_mask(8'h00);
        send_mask(8'hFF);
        send_mask(8'h01);
        send_mask(8'h80);
        send_mask(8'h55);
        send_mask(8'hAA);
        drain();

        // column length cut below the running index, then full-scale overflow
        reg_write(REG_TOP_STEP, 32'h8000_0000);
        reg_write(REG_ROW_SPACING, 32'h0000_0000);
        reg_write(REG_COLUMN_LEN, 32'd4);
        reg_write(REG_WIN_STEP, 32'h4000_0000);
        reg_write(REG_AMPLITUDE, 32'd32767);
        repeat (5) send_mask(8'hFF);
        send_mask(8'h0F);
        send_mask(8'hF0);
        drain();

        // zero and one sample columns
        reg_write(REG_COLUMN_LEN, 32'd0);
        send_mask(8'h3C);
        send_mask(8'hFF);
        drain();
        reg_write(REG_COLUMN_LEN, 32'd1);
        send_mask(8'hC3);
        drain();

        // wrapping steps, zero gain then full gain
        reg_write(REG_TOP_STEP, 32'hFFFF_FFFF);
        reg_write(REG_ROW_SPACING, 32'hFFFF_FFFF);
        reg_write(REG_WIN_STEP, 32'hFFFF_FFFF);
        reg_write(REG_AMPLITUDE, 32'd0);
        reg_write(REG_COLUMN_LEN, 32'd2);
        send_mask(8'hFF);
        send_mask(8'h81);
        drain();
        reg_write(REG_AMPLITUDE, 32'd32767);
        send_mask(8'hFF);
        send_mask(8'h7E);
        send_mask(8'hFF);
        drain();

        // longest column, smallest gain
        reg_write(REG_COLUMN_LEN, 32'd65535);
        reg_write(REG_AMPLITUDE, 32'd1);
        reg_write(REG_TOP_STEP, 32'h0000_0000);
        reg_write(REG_ROW_SPACING, 32'h8000_0000);
        reg_write(REG_WIN_STEP, 32'h0000_0000);
        send_mask(8'hFF);
        send_mask(8'h01);
        send_mask(8'h80);
        drain();

        while (items_queued < 1825) begin
            if ($urandom_range(3) != 0) begin
                reg_write(REG_TOP_STEP, pick_step());
            end
            if ($urandom_range(3) != 0) begin
                reg_write(REG_ROW_SPACING, pick_step());
            end
            if ($urandom_range(3) != 0) begin
                reg_write(REG_WIN_STEP, pick_step());
            end
            if ($urandom_range(2) != 0) begin
                case ($urandom_range(9))
                    0: reg_write(REG_COLUMN_LEN, $urandom_range(1));
                    1: reg_write(REG_COLUMN_LEN, 32'd65535);
                    2: reg_write(REG_COLUMN_LEN, $urandom);
                    default: reg_write(REG_COLUMN_LEN, $urandom_range(2, 48));
                endcase
            end
            if ($urandom_range(2) != 0) begin
                case ($urandom_range(7))
                    0: reg_write(REG_AMPLITUDE, 32'd0);
                    1: reg_write(REG_AMPLITUDE, 32'd32767);
                    2: reg_write(REG_AMPLITUDE, 32'd4095);
                    default: reg_write(REG_AMPLITUDE, $urandom_range(32767));
                endcase
            end
            burst = $urandom_range(10, 120);
            repeat (burst) begin
                case ($urandom_range(9))
                    0: m = 8'h00;
                    1: m = 8'hFF;
                    2: m = 8'h01 << $urandom_range(7);
                    default: m = 8'($urandom);
                endcase
                send_mask(m);
            end
            drain();
        end

        drain();
        repeat (40) @(negedge i_clk);
        if (mismatches == 0 && predicted_samples.size() == 0) begin
            $display("[windowed_multitone_column_synth_core] OK");
        end else begin
            $display("[windowed_multitone_column_synth_core] ERROR");
        end
        $finish;
    end

endmodule
